/* rtl/positional_list_table_unit_assert.svh */
// Assertion macros for the checker file of the positional list table.
// Needs nothing else; pulled in with an include where assertions are written.
`ifndef POSITIONAL_LIST_TABLE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define PLT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion violated");

// next-cycle implication
`define PLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion violated");

`endif

/* rtl/plt_pkg.sv */
// Shared types and constants of the positional list table.
// No dependencies; imported by the interfaces and every module.
`timescale 1ns / 1ps

package plt_pkg;

   localparam int FUNC_W      = 3;
   localparam int POS_W       = 7;
   localparam int CODE_W      = 32;
   localparam int SERV_W      = 8;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 7;
   localparam int SCAN_LANES  = 8;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_MODIFY = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_FIND   = 3'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd3;

   typedef struct packed {
      logic capture;
      logic execute;
      logic scan_step;
      logic finish_find;
   } plt_cmd_type;

   typedef struct packed {
      logic is_find;
      logic scan_hit;
      logic scan_last;
   } plt_status_type;

endpackage

/* rtl/plt_req_if.sv */
// Request channel interface: valid/ready handshake plus operation payload.
// Depends on plt_pkg.
`timescale 1ns / 1ps

interface plt_req_if import plt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [POS_W-1:0]    position;
   logic [CODE_W-1:0]   entry_code;
   logic [SERV_W-1:0]   entry_service;

   modport source (output valid, func, position, entry_code, entry_service, input ready);
   modport sink (input valid, func, position, entry_code, entry_service, output ready);
endinterface

/* rtl/plt_rsp_if.sv */
// Response channel interface: valid/ready handshake plus result payload.
// Depends on plt_pkg.
`timescale 1ns / 1ps

interface plt_rsp_if import plt_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [POS_W-1:0]       found_position;
   logic [COUNT_OUT_W-1:0] entry_count;
   logic                   is_empty;

   modport source (output valid, status, found_position, entry_count, is_empty, input ready);
   modport sink (input valid, status, found_position, entry_count, is_empty, output ready);
endinterface

/* rtl/plt_ctrl.sv */
// Control state machine of the positional list table.
// Depends on plt_pkg; drives the datapath commands and both handshakes.
`timescale 1ns / 1ps

module plt_ctrl import plt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  plt_status_type stat,
   output plt_cmd_type    cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       load;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      load      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.is_find) begin
               cmd.execute = 1'b1;
               state_in    = S_SCAN;
            end else if (out_free) begin
               cmd.execute = 1'b1;
               load        = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_SCAN: begin
            if (stat.scan_hit || stat.scan_last) begin
               if (out_free) begin
                  cmd.finish_find = 1'b1;
                  load            = 1'b1;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/plt_datapath.sv */
// Datapath of the positional list table: entry cell chain, count, match scan
// and response registers. Depends on plt_pkg; driven by plt_ctrl commands.
`timescale 1ns / 1ps

module plt_datapath import plt_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  plt_cmd_type            cmd,
   output plt_status_type         stat,
   input  logic [FUNC_W-1:0]      req_func,
   input  logic [POS_W-1:0]       req_position,
   input  logic [CODE_W-1:0]      req_entry_code,
   input  logic [SERV_W-1:0]      req_entry_service,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [POS_W-1:0]       rsp_found_position,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count,
   output logic                   rsp_is_empty
);

   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int SCAN_W  = CMP_W + 1;
   localparam int GROUPS  = (CAPACITY + SCAN_LANES - 1) / SCAN_LANES;
   localparam int GRP_W   = $clog2(GROUPS + 1);
   localparam int MATCH_W = GROUPS * SCAN_LANES;
   localparam int LANE_W  = $clog2(SCAN_LANES);

   logic [FUNC_W-1:0]      op_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [CODE_W-1:0]      key_ff;
   logic [SERV_W-1:0]      svc_ff;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CODE_W-1:0]      code_ff [CAPACITY];
   logic [SERV_W-1:0]      serv_ff [CAPACITY];
   logic [MATCH_W-1:0]     match_ff, match_in;
   logic [GRP_W-1:0]       group_ff, group_in;
   logic [STATUS_W-1:0]    status_ff;
   logic [POS_W-1:0]       found_ff;
   logic [COUNT_OUT_W-1:0] count_out_ff;
   logic                   empty_ff;

   logic [CMP_W-1:0]       pos_x, cnt_x;
   logic                   list_full, ins_range_ok, pos_ok;
   logic                   do_ins, do_mod, do_rem;
   logic [STATUS_W-1:0]    exec_status;
   logic [MATCH_W-1:0]     match_cap;
   logic [SCAN_LANES-1:0]  lane_bits;
   logic [LANE_W-1:0]      lane_idx;
   logic                   is_find;
   logic [SCAN_W-1:0]      next_base, found_full;

   assign pos_x        = CMP_W'(pos_ff);
   assign cnt_x        = CMP_W'(count_ff);
   assign list_full    = cnt_x >= CMP_W'(CAPACITY);
   assign ins_range_ok = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
   assign pos_ok       = (pos_x != '0) && (pos_x <= cnt_x);
   assign is_find      = op_ff == FUNC_FIND;

   always_comb begin
      exec_status = STATUS_OK;
      do_ins      = 1'b0;
      do_mod      = 1'b0;
      do_rem      = 1'b0;
      case (op_ff)
         FUNC_INSERT: begin
            if (list_full) begin
               exec_status = STATUS_FULL;
            end else if (!ins_range_ok) begin
               exec_status = STATUS_RANGE;
            end else begin
               do_ins = 1'b1;
            end
         end
         FUNC_MODIFY: begin
            if (!pos_ok) begin
               exec_status = STATUS_RANGE;
            end else begin
               do_mod = 1'b1;
            end
         end
         FUNC_REMOVE: begin
            if (!pos_ok) begin
               exec_status = STATUS_RANGE;
            end else begin
               do_rem = 1'b1;
            end
         end
         default: begin
            exec_status = STATUS_OK;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.execute && do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.execute && do_rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // one cell per entry; on the execute command, shifts move the whole chain at once
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      localparam logic [CMP_W-1:0] K_POS = CMP_W'(k + 1);
      logic [CODE_W-1:0] up_code, down_code;
      logic [SERV_W-1:0] up_serv, down_serv;

      if (k == 0) begin : g_first
         assign up_code = code_ff[k];
         assign up_serv = serv_ff[k];
      end else begin : g_mid
         assign up_code = code_ff[k-1];
         assign up_serv = serv_ff[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign down_code = code_ff[k];
         assign down_serv = serv_ff[k];
      end else begin : g_body
         assign down_code = code_ff[k+1];
         assign down_serv = serv_ff[k+1];
      end

      always_ff @(posedge clock) begin
         if (cmd.execute) begin
            if ((do_ins || do_mod) && (K_POS == pos_x)) begin
               code_ff[k] <= key_ff;
               serv_ff[k] <= svc_ff;
            end else if (do_ins && (K_POS > pos_x)) begin
               code_ff[k] <= up_code;
               serv_ff[k] <= up_serv;
            end else if (do_rem && (K_POS >= pos_x)) begin
               code_ff[k] <= down_code;
               serv_ff[k] <= down_serv;
            end
         end
      end

      assign match_cap[k] = (code_ff[k] == key_ff) && (K_POS <= cnt_x);
   end

   if (MATCH_W > CAPACITY) begin : g_pad
      assign match_cap[MATCH_W-1:CAPACITY] = '0;
   end

   assign lane_bits = match_ff[SCAN_LANES-1:0];

   always_comb begin
      lane_idx = '0;
      for (int i = SCAN_LANES - 1; i >= 0; i--) begin
         if (lane_bits[i]) begin
            lane_idx = LANE_W'(i);
         end
      end
   end

   assign next_base  = (SCAN_W'(group_ff) + SCAN_W'(1)) << LANE_W;
   assign found_full = (SCAN_W'(group_ff) << LANE_W) + SCAN_W'(lane_idx) + SCAN_W'(1);

   assign stat.is_find   = is_find;
   assign stat.scan_hit  = |lane_bits;
   assign stat.scan_last = next_base >= SCAN_W'(count_ff);

   always_comb begin
      match_in = match_ff;
      group_in = group_ff;
      if (cmd.execute && is_find) begin
         match_in = match_cap;
         group_in = '0;
      end else if (cmd.scan_step) begin
         match_in = match_ff >> SCAN_LANES;
         group_in = group_ff + GRP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
      group_ff <= group_in;
      if (cmd.capture) begin
         op_ff  <= req_func;
         pos_ff <= req_position;
         key_ff <= req_entry_code;
         svc_ff <= req_entry_service;
      end
      if (cmd.execute && !is_find) begin
         status_ff    <= exec_status;
         found_ff     <= '0;
         count_out_ff <= COUNT_OUT_W'(count_in);
         empty_ff     <= count_in == '0;
      end else if (cmd.finish_find) begin
         status_ff    <= stat.scan_hit ? STATUS_OK : STATUS_NOTFOUND;
         found_ff     <= stat.scan_hit ? POS_W'(found_full) : '0;
         count_out_ff <= COUNT_OUT_W'(count_ff);
         empty_ff     <= count_ff == '0;
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_found_position = found_ff;
   assign rsp_entry_count    = count_out_ff;
   assign rsp_is_empty       = empty_ff;

endmodule

/* rtl/positional_list_table_unit.sv */
// Positional list table: an ordered list of key/service records kept packed at
// positions 1..count, with insert, modify, remove, find and query operations.
// Every operation takes one transaction and returns one. Insert, modify, remove
// and query are captured and then executed, once the output register is free,
// with the result registered for the response. Find compares all entries at
// once, then scans the match bits 8 positions per cycle until the group with
// the first match or the last group (at least 1 group, at most ceil(count/8)
// for a non-empty list). One operation is in flight at a time; a new request
// is accepted while the previous response still waits in its output register.
`timescale 1ns / 1ps

module positional_list_table_unit import plt_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input logic        clock,
   input logic        reset,
   plt_req_if.sink    req_bus,
   plt_rsp_if.source  rsp_bus
);

   plt_cmd_type    cmd;
   plt_status_type stat;

   plt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   plt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_func           (req_bus.func),
      .req_position       (req_bus.position),
      .req_entry_code     (req_bus.entry_code),
      .req_entry_service  (req_bus.entry_service),
      .rsp_status         (rsp_bus.status),
      .rsp_found_position (rsp_bus.found_position),
      .rsp_entry_count    (rsp_bus.entry_count),
      .rsp_is_empty       (rsp_bus.is_empty)
   );

endmodule

/* rtl/plt_checker.sv */
// Port-level checks on the response channel of the positional list table,
// bound to positional_list_table_unit. Depends on plt_pkg and the assert macros.
`timescale 1ns / 1ps
`include "positional_list_table_unit_assert.svh"

module plt_checker import plt_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [STATUS_W-1:0]    status,
   input logic [POS_W-1:0]       found_position,
   input logic [COUNT_OUT_W-1:0] entry_count,
   input logic                   is_empty
);

   `PLT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `PLT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(status) && $stable(found_position) && $stable(entry_count) && $stable(is_empty))
   `PLT_ASSERT_IMP(a_empty_count, clock, reset, rsp_valid && is_empty, entry_count == '0)
   `PLT_ASSERT_IMP(a_found_ok, clock, reset, rsp_valid && (found_position != '0), status == STATUS_OK)

endmodule

bind positional_list_table_unit plt_checker u_plt_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .status         (rsp_bus.status),
   .found_position (rsp_bus.found_position),
   .entry_count    (rsp_bus.entry_count),
   .is_empty       (rsp_bus.is_empty)
);
